[src/ps2mct_pkg.sv]
// ----------------------------------------------------------------------------
// ps2mct_pkg
// shared types and constants of the mouse packet cursor tracker
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int POS_BITS   = 12;
  localparam int TEXT_COLS  = 80;
  localparam int TEXT_ROWS  = 25;

  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SENS_W     = 9;
  localparam int SIZE_W     = 13;
  localparam int WHEEL_W    = 32;
  localparam int BTN_W      = 5;
  localparam int LIM_W      = (SIZE_W > POS_BITS) ? SIZE_W : POS_BITS;
  localparam int SUM_W      = POS_BITS + 2;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  localparam int SENS_MIN     = 25;
  localparam int SENS_MAX     = 400;
  localparam int SENS_RESET   = 100;
  localparam int TEXT_X_LIMIT = 639;
  localparam int TEXT_Y_LIMIT = 399;
  localparam int X_RESET      = 320;
  localparam int Y_RESET      = 200;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 400;

  // divide by 100 as multiply by reciprocal, exact for magnitudes below 2^16
  localparam int MAG_W       = 16;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP       = 83887;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int QUO_W       = 10;
  localparam int QUO_MAX     = (SENS_MAX * 128) / 100;

  typedef enum logic [1:0] {
    OP_PS2       = 2'd0,
    OP_USB       = 2'd1,
    OP_WHEEL_CLR = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIVE_BUTTON   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAPHICS_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;

  typedef struct packed {
    logic              upd;
    logic              move;
    logic              set_btn;
    logic [BTN_W-1:0]  btn;
    logic              clear;
    logic signed [7:0] wheel;
  } cmd_t;

endpackage

[src/ps2mct_if.sv]
// ----------------------------------------------------------------------------
// ps2mct interfaces
// request, result and configuration channels of the cursor tracker
// ----------------------------------------------------------------------------
interface ps2mct_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [7:0]        ps2_byte;
  logic signed [7:0] usb_dx;
  logic signed [7:0] usb_dy;
  logic signed [7:0] usb_wheel;
  logic [7:0]        usb_buttons;

  modport source (
    output valid, operation, ps2_byte, usb_dx, usb_dy, usb_wheel, usb_buttons,
    input  ready
  );
  modport sink (
    input  valid, operation, ps2_byte, usb_dx, usb_dy, usb_wheel, usb_buttons,
    output ready
  );
endinterface

interface ps2mct_rsp_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      position_updated;
  logic [ps2mct_pkg::POS_BITS-1:0]           x_position;
  logic [ps2mct_pkg::POS_BITS-1:0]           y_position;
  logic [ps2mct_pkg::BTN_W-1:0]              button_state;
  logic signed [ps2mct_pkg::WHEEL_W-1:0]     wheel_sum;
  logic [ps2mct_pkg::COL_W-1:0]              text_column;
  logic [ps2mct_pkg::ROW_W-1:0]              text_row;

  modport source (
    output valid, position_updated, x_position, y_position, button_state,
           wheel_sum, text_column, text_row,
    input  ready
  );
  modport sink (
    input  valid, position_updated, x_position, y_position, button_state,
           wheel_sum, text_column, text_row,
    output ready
  );
endinterface

interface ps2mct_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ps2mct_pkg::CFG_IDX_W-1:0]      index;
  logic [ps2mct_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/ps2_mouse_packet_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// assembles ps/2 mouse packets, applies ps/2 and usb movement to a clamped
// cursor, tracks buttons and a wheel total, reports the text cell
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  req      in         operation, ps2_byte, usb_dx, usb_dy, usb_wheel, usb_buttons
//  rsp      out        position_updated, x/y position, buttons, wheel, text cell
//  cfg      in         register index and write data, always ready
//
//  one transaction per cycle sustained while results are taken; each result
//  passes stages a to d: packet assembly, delta times sensitivity, reciprocal
//  divide by 100, cursor add and clamp into the result register
//  synchronous reset, no clearing pass
//  a stalled result holds the pipe back one stage at a time through the valid
//  bits, so bubbles ahead of it still take new requests
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker (
  input  logic          clk,
  input  logic          rst,
  ps2mct_req_if.sink    req,
  ps2mct_rsp_if.source  rsp,
  ps2mct_cfg_if.sink    cfg
);

  localparam int PB = ps2mct_pkg::POS_BITS;

  // configuration
  logic                               wheel_mode;
  logic                               five_button_mode;
  logic [ps2mct_pkg::SENS_W-1:0]      sensitivity_percent;
  logic                               graphics_mode;
  logic [ps2mct_pkg::SIZE_W-1:0]      screen_width;
  logic [ps2mct_pkg::SIZE_W-1:0]      screen_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode          <= 1'b0;
      five_button_mode    <= 1'b0;
      sensitivity_percent <= ps2mct_pkg::SENS_W'(ps2mct_pkg::SENS_RESET);
      graphics_mode       <= 1'b0;
      screen_width        <= ps2mct_pkg::SIZE_W'(ps2mct_pkg::WIDTH_RESET);
      screen_height       <= ps2mct_pkg::SIZE_W'(ps2mct_pkg::HEIGHT_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ps2mct_pkg::CFG_WHEEL_MODE:    wheel_mode          <= cfg.data[0];
        ps2mct_pkg::CFG_FIVE_BUTTON:   five_button_mode    <= cfg.data[0];
        ps2mct_pkg::CFG_SENSITIVITY:   sensitivity_percent <= cfg.data[ps2mct_pkg::SENS_W-1:0];
        ps2mct_pkg::CFG_GRAPHICS_MODE: graphics_mode       <= cfg.data[0];
        ps2mct_pkg::CFG_SCREEN_WIDTH:  screen_width        <= cfg.data[ps2mct_pkg::SIZE_W-1:0];
        ps2mct_pkg::CFG_SCREEN_HEIGHT: screen_height       <= cfg.data[ps2mct_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp limits, derived from configuration through a register
  logic [PB-1:0]                  lim_x;
  logic [PB-1:0]                  lim_y;
  logic [PB-1:0]                  lim_x_next;
  logic [PB-1:0]                  lim_y_next;
  logic [ps2mct_pkg::LIM_W-1:0]   w_m1;
  logic [ps2mct_pkg::LIM_W-1:0]   h_m1;

  always_comb begin
    w_m1 = (screen_width == '0) ? '0
         : ps2mct_pkg::LIM_W'(screen_width) - ps2mct_pkg::LIM_W'(1);
    h_m1 = (screen_height == '0) ? '0
         : ps2mct_pkg::LIM_W'(screen_height) - ps2mct_pkg::LIM_W'(1);
    if (!graphics_mode) begin
      lim_x_next = PB'(ps2mct_pkg::TEXT_X_LIMIT);
      lim_y_next = PB'(ps2mct_pkg::TEXT_Y_LIMIT);
    end else begin
      lim_x_next = (w_m1 > ps2mct_pkg::LIM_W'(ps2mct_pkg::POS_MAX))
                 ? ps2mct_pkg::POS_MAX : w_m1[PB-1:0];
      lim_y_next = (h_m1 > ps2mct_pkg::LIM_W'(ps2mct_pkg::POS_MAX))
                 ? ps2mct_pkg::POS_MAX : h_m1[PB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    lim_x <= lim_x_next;
    lim_y <= lim_y_next;
  end

  // handshake chain
  logic a_v, b_v, c_v, d_v;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic acc;
  logic load_d;

  assign rdy_d     = !d_v || rsp.ready;
  assign rdy_c     = !c_v || rdy_d;
  assign rdy_b     = !b_v || rdy_c;
  assign rdy_a     = !a_v || rdy_b;
  assign req.ready = rdy_a;
  assign acc       = req.valid && rdy_a;
  assign load_d    = c_v && rdy_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      if (rdy_a) a_v <= req.valid;
      if (rdy_b) b_v <= a_v;
      if (rdy_c) c_v <= b_v;
      if (rdy_d) d_v <= c_v;
    end
  end

  // packet assembly at request time
  logic [1:0]        byte_pos;
  logic [1:0]        byte_pos_next;
  logic [7:0]        pkt [3];
  logic              store_en;
  logic              complete;
  ps2mct_pkg::cmd_t  cmd_in;
  logic signed [7:0] dx_in;
  logic signed [7:0] dy_in;

  assign complete = (byte_pos == 2'd3) || ((byte_pos == 2'd2) && !wheel_mode);

  always_comb begin
    cmd_in        = '0;
    dx_in         = '0;
    dy_in         = '0;
    store_en      = 1'b0;
    byte_pos_next = byte_pos;
    unique case (ps2mct_pkg::op_t'(req.operation))
      ps2mct_pkg::OP_PS2: begin
        if (!((byte_pos == 2'd0) && !req.ps2_byte[3])) begin
          if (!complete) begin
            store_en      = 1'b1;
            byte_pos_next = byte_pos + 2'd1;
          end else begin
            store_en       = (byte_pos != 2'd3);
            byte_pos_next  = 2'd0;
            cmd_in.upd     = 1'b1;
            cmd_in.move    = 1'b1;
            cmd_in.set_btn = 1'b1;
            cmd_in.btn     = {2'b00, pkt[0][2:0]};
            if (wheel_mode && (byte_pos == 2'd3)) begin
              cmd_in.wheel = {{4{req.ps2_byte[3]}}, req.ps2_byte[3:0]};
              if (five_button_mode) begin
                cmd_in.btn[3] = req.ps2_byte[4];
                cmd_in.btn[4] = req.ps2_byte[5];
              end
            end
            dx_in = pkt[1];
            dy_in = (byte_pos == 2'd2) ? req.ps2_byte : pkt[2];
          end
        end
      end
      ps2mct_pkg::OP_USB: begin
        cmd_in.upd     = 1'b1;
        cmd_in.move    = 1'b1;
        cmd_in.set_btn = 1'b1;
        cmd_in.btn     = {2'b00, req.usb_buttons[2:0]};
        cmd_in.wheel   = req.usb_wheel;
        dx_in          = req.usb_dx;
        dy_in          = req.usb_dy;
      end
      ps2mct_pkg::OP_WHEEL_CLR: begin
        cmd_in.clear = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= 2'd0;
    end else if (acc) begin
      byte_pos <= byte_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && store_en) begin
      pkt[byte_pos] <= req.ps2_byte;
    end
  end

  // stage a: decoded transaction
  ps2mct_pkg::cmd_t  a_cmd;
  logic signed [7:0] a_dx;
  logic signed [7:0] a_dy;

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_cmd <= cmd_in;
      a_dx  <= dx_in;
      a_dy  <= dy_in;
    end
  end

  // stage b: magnitude times sensitivity
  logic [ps2mct_pkg::SENS_W-1:0] s_sat;
  logic [7:0]                    ax;
  logic [7:0]                    ay;
  logic [16:0]                   px;
  logic [16:0]                   py;
  ps2mct_pkg::cmd_t              b_cmd;
  logic                          b_sx;
  logic                          b_sy;
  logic [ps2mct_pkg::MAG_W-1:0]  b_mx;
  logic [ps2mct_pkg::MAG_W-1:0]  b_my;

  always_comb begin
    if (sensitivity_percent < ps2mct_pkg::SENS_W'(ps2mct_pkg::SENS_MIN)) begin
      s_sat = ps2mct_pkg::SENS_W'(ps2mct_pkg::SENS_MIN);
    end else if (sensitivity_percent > ps2mct_pkg::SENS_W'(ps2mct_pkg::SENS_MAX)) begin
      s_sat = ps2mct_pkg::SENS_W'(ps2mct_pkg::SENS_MAX);
    end else begin
      s_sat = sensitivity_percent;
    end
    ax = a_dx[7] ? 8'(-a_dx) : 8'(a_dx);
    ay = a_dy[7] ? 8'(-a_dy) : 8'(a_dy);
    px = {9'b0, ax} * {8'b0, s_sat};
    py = {9'b0, ay} * {8'b0, s_sat};
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_cmd <= a_cmd;
      b_sx  <= a_dx[7];
      b_sy  <= a_dy[7];
      b_mx  <= px[ps2mct_pkg::MAG_W-1:0];
      b_my  <= py[ps2mct_pkg::MAG_W-1:0];
    end
  end

  // stage c: divide by 100
  logic [ps2mct_pkg::PROD_W-1:0] qpx;
  logic [ps2mct_pkg::PROD_W-1:0] qpy;
  ps2mct_pkg::cmd_t              c_cmd;
  logic                          c_sx;
  logic                          c_sy;
  logic [ps2mct_pkg::QUO_W-1:0]  c_qx;
  logic [ps2mct_pkg::QUO_W-1:0]  c_qy;

  always_comb begin
    qpx = {{ps2mct_pkg::RECIP_W{1'b0}}, b_mx}
        * ps2mct_pkg::PROD_W'(ps2mct_pkg::RECIP);
    qpy = {{ps2mct_pkg::RECIP_W{1'b0}}, b_my}
        * ps2mct_pkg::PROD_W'(ps2mct_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_cmd <= b_cmd;
      c_sx  <= b_sx;
      c_sy  <= b_sy;
      c_qx  <= qpx[ps2mct_pkg::RECIP_SHIFT +: ps2mct_pkg::QUO_W];
      c_qy  <= qpy[ps2mct_pkg::RECIP_SHIFT +: ps2mct_pkg::QUO_W];
    end
  end

  // stage d: cursor, buttons, wheel and result
  logic [PB-1:0]                      cursor_x;
  logic [PB-1:0]                      cursor_y;
  logic [ps2mct_pkg::BTN_W-1:0]       buttons_held;
  logic [ps2mct_pkg::WHEEL_W-1:0]     wheel_accum;

  logic signed [ps2mct_pkg::QUO_W:0]  dxs;
  logic signed [ps2mct_pkg::QUO_W:0]  dys;
  logic signed [ps2mct_pkg::SUM_W-1:0] sum_x;
  logic signed [ps2mct_pkg::SUM_W-1:0] sum_y;
  logic [PB-1:0]                      clamp_x;
  logic [PB-1:0]                      clamp_y;
  logic [PB-1:0]                      cursor_x_next;
  logic [PB-1:0]                      cursor_y_next;
  logic [ps2mct_pkg::BTN_W-1:0]       buttons_held_next;
  logic [ps2mct_pkg::WHEEL_W-1:0]     wheel_out;
  logic [ps2mct_pkg::WHEEL_W-1:0]     wheel_accum_next;
  logic [PB-4:0]                      col_raw;
  logic [PB-5:0]                      row_raw;
  logic [ps2mct_pkg::COL_W-1:0]       col_next;
  logic [ps2mct_pkg::ROW_W-1:0]       row_next;

  always_comb begin
    dxs = c_sx ? -$signed({1'b0, c_qx}) : $signed({1'b0, c_qx});
    dys = c_sy ? -$signed({1'b0, c_qy}) : $signed({1'b0, c_qy});
    sum_x = $signed({2'b00, cursor_x}) + ps2mct_pkg::SUM_W'(dxs);
    sum_y = $signed({2'b00, cursor_y}) - ps2mct_pkg::SUM_W'(dys);

    if (sum_x < 0) begin
      clamp_x = '0;
    end else if (sum_x > $signed({2'b00, lim_x})) begin
      clamp_x = lim_x;
    end else begin
      clamp_x = sum_x[PB-1:0];
    end
    if (sum_y < 0) begin
      clamp_y = '0;
    end else if (sum_y > $signed({2'b00, lim_y})) begin
      clamp_y = lim_y;
    end else begin
      clamp_y = sum_y[PB-1:0];
    end

    cursor_x_next     = c_cmd.move ? clamp_x : cursor_x;
    cursor_y_next     = c_cmd.move ? clamp_y : cursor_y;
    buttons_held_next = c_cmd.set_btn ? c_cmd.btn : buttons_held;
    wheel_out         = wheel_accum + ps2mct_pkg::WHEEL_W'(c_cmd.wheel);
    wheel_accum_next  = c_cmd.clear ? '0 : wheel_out;

    // cell size 8 by 16 pixels
    col_raw  = cursor_x_next[PB-1:3];
    row_raw  = cursor_y_next[PB-1:4];
    col_next = (int'(col_raw) > ps2mct_pkg::TEXT_COLS - 1)
             ? ps2mct_pkg::COL_W'(ps2mct_pkg::TEXT_COLS - 1)
             : ps2mct_pkg::COL_W'(col_raw);
    row_next = (int'(row_raw) > ps2mct_pkg::TEXT_ROWS - 1)
             ? ps2mct_pkg::ROW_W'(ps2mct_pkg::TEXT_ROWS - 1)
             : ps2mct_pkg::ROW_W'(row_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= PB'(ps2mct_pkg::X_RESET);
      cursor_y     <= PB'(ps2mct_pkg::Y_RESET);
      buttons_held <= '0;
      wheel_accum  <= '0;
    end else if (load_d) begin
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      buttons_held <= buttons_held_next;
      wheel_accum  <= wheel_accum_next;
    end
  end

  logic                               d_upd;
  logic [PB-1:0]                      d_x;
  logic [PB-1:0]                      d_y;
  logic [ps2mct_pkg::BTN_W-1:0]       d_btn;
  logic [ps2mct_pkg::WHEEL_W-1:0]     d_wheel;
  logic [ps2mct_pkg::COL_W-1:0]       d_col;
  logic [ps2mct_pkg::ROW_W-1:0]       d_row;

  always_ff @(posedge clk) begin
    if (load_d) begin
      d_upd   <= c_cmd.upd;
      d_x     <= cursor_x_next;
      d_y     <= cursor_y_next;
      d_btn   <= buttons_held_next;
      d_wheel <= wheel_out;
      d_col   <= col_next;
      d_row   <= row_next;
    end
  end

  assign rsp.valid            = d_v;
  assign rsp.position_updated = d_upd;
  assign rsp.x_position       = d_x;
  assign rsp.y_position       = d_y;
  assign rsp.button_state     = d_btn;
  assign rsp.wheel_sum        = $signed(d_wheel);
  assign rsp.text_column      = d_col;
  assign rsp.text_row         = d_row;

`ifndef ASSERT_OFF
  a_no_move_holds_cursor: assert property (@(posedge clk) disable iff (rst)
    (load_d && !c_cmd.move) |=> ($stable(cursor_x) && $stable(cursor_y)))
    else $error("cursor changed on a transaction without movement");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    c_v |-> ((c_qx <= ps2mct_pkg::QUO_W'(ps2mct_pkg::QUO_MAX))
          && (c_qy <= ps2mct_pkg::QUO_W'(ps2mct_pkg::QUO_MAX))))
    else $error("scaled delta out of range");

  a_wheel_cleared: assert property (@(posedge clk) disable iff (rst)
    (load_d && c_cmd.clear) |=> (wheel_accum == '0))
    else $error("wheel total not cleared");

  a_packet_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && (req.operation == ps2mct_pkg::OP_PS2) && complete) |=> (byte_pos == 2'd0))
    else $error("byte position not reset after packet end");
`endif

endmodule
